FILE: hdl/lops_pkg.sv
package lops_pkg;

   localparam int MAX_STEPS    = 4;
   localparam int STEP_IDX_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int STEP_W       = 3;
   localparam int ON_W         = 24;
   localparam int OFF_W        = 24;
   localparam int REP_W        = 16;
   localparam int SEC_W        = 25;
   localparam int WORD_W       = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 8;
   localparam int RSP_FIELDS_W = 1 + STEP_W + 1;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_STEP_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_WORD_3 = 3'd4;

   typedef struct packed {
      logic              finished;
      logic [STEP_W-1:0] step_now;
      logic              led_on;
   } status_type;

endpackage

FILE: hdl/lops_step_engine.sv
module lops_step_engine
   import lops_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  tick,
   input  logic [WORD_W-1:0]     step_word,
   input  logic [STEP_W-1:0]     active_steps,
   output logic [STEP_IDX_W-1:0] step_sel,
   output status_type            status_next
);

   logic              led_ff, led_in;
   logic [STEP_W-1:0] pointer_ff, pointer_in;
   logic [SEC_W-1:0]  sec_ff, sec_in;
   logic [REP_W-1:0]  rep_ff, rep_in;

   logic [ON_W-1:0]   on_s;
   logic [OFF_W-1:0]  off_s;
   logic [REP_W-1:0]  reps;
   logic [SEC_W-1:0]  total;
   logic [SEC_W:0]    sec_inc;
   logic [REP_W:0]    rep_inc;
   logic              running;

   assign on_s    = step_word[ON_W-1:0];
   assign off_s   = step_word[ON_W+OFF_W-1:ON_W];
   assign reps    = step_word[WORD_W-1:ON_W+OFF_W];
   assign total   = {1'b0, on_s} + {1'b0, off_s};
   assign sec_inc = {1'b0, sec_ff} + {{SEC_W{1'b0}}, 1'b1};
   assign rep_inc = {1'b0, rep_ff} + {{REP_W{1'b0}}, 1'b1};
   assign running = pointer_ff < active_steps;

   // table index only matters while running, when the pointer is below four
   assign step_sel = pointer_ff[STEP_IDX_W-1:0];

   always_comb begin
      led_in     = led_ff;
      pointer_in = pointer_ff;
      sec_in     = sec_ff;
      rep_in     = rep_ff;
      if (advance && tick && running) begin
         // zero-length step: level untouched
         if (sec_ff < {1'b0, on_s}) begin
            led_in = 1'b1;
         end else if (sec_ff < total) begin
            led_in = 1'b0;
         end
         if (sec_inc >= {1'b0, total}) begin
            sec_in = '0;
            if (rep_inc >= {1'b0, reps}) begin
               rep_in     = '0;
               pointer_in = pointer_ff + STEP_W'(1);
            end else begin
               rep_in = rep_inc[REP_W-1:0];
            end
         end else begin
            sec_in = sec_inc[SEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff     <= 1'b0;
         pointer_ff <= '0;
         sec_ff     <= '0;
         rep_ff     <= '0;
      end else begin
         led_ff     <= led_in;
         pointer_ff <= pointer_in;
         sec_ff     <= sec_in;
         rep_ff     <= rep_in;
      end
   end

   assign status_next.led_on   = led_in;
   assign status_next.step_now = pointer_in;
   assign status_next.finished = pointer_in >= active_steps;

endmodule

FILE: hdl/led_on_off_program_sequencer_core.sv
// LED on/off program sequencer.
// Requests arrive on the req_ stream, one per tick slot: req_tdata[0] = 1 means one
// second has elapsed, 0 leaves the sequence where it is. Every request gives exactly one
// response on the rsp_ stream carrying the LED level, the current step index and the
// finished flag as they stand after that request.
// The program (step count and up to four packed step words) is written through the csr_
// port, by the user only while no request is in flight; the block does not enforce this.
// Step words outside the built step table are ignored. An accepted request passes the
// input register, then the counter update feeding the response register, which drives
// rsp_tvalid. Throughput is one request per cycle while the receiver takes responses.
// When the receiver stalls, the response register holds; one more request can sit in the
// input register, after which req_tready drops until the response is taken.
// Synchronous reset clears the program, the LED (off), the counters and both valid flags;
// the step count resets to zero, so the block reports finished until programmed.
module led_on_off_program_sequencer_core
   import lops_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: [0] tick, rest zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // response: [0] led_on, [3:1] step_now, [4] finished, rest zero
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   logic              in_valid_ff, in_valid_in;
   logic              in_tick_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff;
   status_type        status_next;
   logic [STEP_W-1:0] step_count_ff;
   logic [WORD_W-1:0] step_word_ff [MAX_STEPS];
   logic [STEP_W-1:0] active_steps;
   logic [CSR_IDX_W-1:0] word_sel;
   logic              advance;
   logic [STEP_IDX_W-1:0] engine_sel;

   // configuration
   assign word_sel = csr_index - REG_STEP_WORD_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= '0;
         for (int i = 0; i < MAX_STEPS; i++) begin
            step_word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_STEP_COUNT) begin
            step_count_ff <= csr_wdata[STEP_W-1:0];
         end else if (csr_index >= REG_STEP_WORD_0 && csr_index <= REG_STEP_WORD_3
                      && 32'(word_sel) < MAX_STEPS) begin
            step_word_ff[word_sel[STEP_IDX_W-1:0]] <= csr_wdata;
         end
      end
   end

   assign active_steps = (32'(step_count_ff) > MAX_STEPS) ? STEP_W'(MAX_STEPS)
                                                          : step_count_ff;

   // pipeline control
   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (in_valid_ff && advance) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_tick_ff <= req_tdata[0];
      end
      if (in_valid_ff && advance) begin
         status_ff <= status_next;
      end
   end

   lops_step_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .advance      (in_valid_ff && advance),
      .tick         (in_tick_ff),
      .step_word    (step_word_ff[engine_sel]),
      .active_steps (active_steps),
      .step_sel     (engine_sel),
      .status_next  (status_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_FIELDS_W){1'b0}}, status_ff};

endmodule

FILE: hdl/lops_checker.sv
module lops_checker
   import lops_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // nothing may be pending in the response register straight after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // an empty response register always leaves room for a request
   a_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with response register empty");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:RSP_FIELDS_W] == '0)
      else $error("response padding not zero");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[STEP_W:1]) <= MAX_STEPS)
      else $error("step index beyond program");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind led_on_off_program_sequencer_core lops_checker u_lops_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
